FILE: sv/tpf_pkg.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO package
// Shared constants, codes and payload types of the tagged packet FIFO.
// ----------------------------------------------------------------------------
package tpf_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_LEN_DEF = 64;

	localparam int CFG_W = 5;
	localparam int LEN_W = 7;
	localparam int OCC_W = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int PEND_W  = $clog2(Q_DEPTH + 3);

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [7:0] tag;
	} tpf_in_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_last;
		logic [7:0]       out_tag;
		logic [LEN_W-1:0] packet_length;
		logic [OCC_W-1:0] occupancy;
		logic [1:0]       status;
	} tpf_out_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [7:0]       tag;
	} tpf_hdr_t;

	typedef struct packed {
		logic             stream;
		logic [7:0]       tag;
		logic [LEN_W-1:0] length;
		logic [OCC_W-1:0] occ;
		logic [1:0]       status;
	} tpf_cmd_t;

endpackage

FILE: sv/tpf_front.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO front end
// Takes input beats, runs puts against the ring, looks up the head packet
// for gets and queries, and issues result commands to the back end.
// ----------------------------------------------------------------------------
module tpf_front #(
	parameter int SLOTS   = tpf_pkg::SLOTS_DEF,
	parameter int MAX_LEN = tpf_pkg::MAX_LEN_DEF,
	localparam int SLOT_W = $clog2(SLOTS),
	localparam int CNT_W  = $clog2(SLOTS + 1),
	localparam int ADDR_W = $clog2(SLOTS * MAX_LEN)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [tpf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tpf_pkg::tpf_in_t             in_item,
	input  logic                         q_full,
	output logic                         q_push,
	output tpf_pkg::tpf_cmd_t            q_cmd,
	output logic [SLOT_W-1:0]            q_slot,
	input  logic                         stream_done,
	output logic                         mem_we,
	output logic [ADDR_W-1:0]            mem_waddr,
	output logic [7:0]                   mem_wdata
);

	localparam logic [tpf_pkg::LEN_W-1:0] MAX_L = tpf_pkg::LEN_W'(MAX_LEN);

	function automatic logic [CNT_W-1:0] ring_of(input logic [tpf_pkg::CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > SLOTS) begin
			r = CNT_W'(SLOTS);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	tpf_pkg::tpf_in_t item_s1;
	logic             valid_s1;
	logic             wait_s1;

	logic [SLOT_W-1:0]          wslot_q, rslot_q;
	logic [CNT_W-1:0]           count_q, ring_q;
	logic [tpf_pkg::LEN_W-1:0]  woff_q;
	logic                       ovf_q;
	logic [tpf_pkg::PEND_W-1:0] pend_q;
	tpf_pkg::tpf_hdr_t          head_q;
	tpf_pkg::tpf_hdr_t          hdr_mem [SLOTS];

	logic [SLOT_W-1:0]          wslot_d, rslot_d, wslot_nx, rslot_nx;
	logic [CNT_W-1:0]           count_d, ws_inc, rs_inc;
	logic [tpf_pkg::LEN_W-1:0]  woff_d, woff_inc, head_len;
	logic                       ovf_d, done, wait_d, hdr_we, pend_inc;
	logic [tpf_pkg::PEND_W-1:0] pend_d;

	assign ws_inc   = CNT_W'(wslot_q) + CNT_W'(1);
	assign rs_inc   = CNT_W'(rslot_q) + CNT_W'(1);
	assign wslot_nx = (ws_inc >= ring_q) ? '0 : SLOT_W'(ws_inc);
	assign rslot_nx = (rs_inc >= ring_q) ? '0 : SLOT_W'(rs_inc);
	assign woff_inc = (woff_q <= MAX_L) ? woff_q + tpf_pkg::LEN_W'(1) : woff_q;
	assign head_len = (head_q.length > MAX_L) ? MAX_L : head_q.length;

	assign mem_waddr = ADDR_W'(wslot_q) * ADDR_W'(MAX_LEN) + ADDR_W'(woff_q);
	assign mem_wdata = item_s1.data_byte;
	assign q_slot    = rslot_q;
	assign in_ready  = !valid_s1 || done;

	always_comb begin
		done     = 1'b0;
		wait_d   = wait_s1;
		q_push   = 1'b0;
		q_cmd    = '0;
		mem_we   = 1'b0;
		hdr_we   = 1'b0;
		pend_inc = 1'b0;
		wslot_d  = wslot_q;
		rslot_d  = rslot_q;
		count_d  = count_q;
		woff_d   = woff_q;
		ovf_d    = ovf_q;
		case (item_s1.op)
			tpf_pkg::OP_PUT: begin
				if (valid_s1 && pend_q == '0 && (!item_s1.last_byte || !q_full)) begin
					done   = 1'b1;
					mem_we = (woff_q < MAX_L) && (count_q < ring_q);
					ovf_d  = ovf_q || ((woff_q < MAX_L) && (count_q >= ring_q));
					woff_d = woff_inc;
					if (item_s1.last_byte) begin
						woff_d       = '0;
						ovf_d        = 1'b0;
						q_push       = 1'b1;
						q_cmd.stream = 1'b0;
						if (woff_inc > MAX_L) begin
							q_cmd.status = tpf_pkg::ST_LONG;
							q_cmd.occ    = tpf_pkg::OCC_W'(count_q);
						end else if (ovf_q || count_q >= ring_q) begin
							q_cmd.status = tpf_pkg::ST_FULL;
							q_cmd.occ    = tpf_pkg::OCC_W'(count_q);
						end else begin
							hdr_we       = 1'b1;
							wslot_d      = wslot_nx;
							count_d      = count_q + CNT_W'(1);
							q_cmd.status = tpf_pkg::ST_OK;
							q_cmd.length = woff_inc;
							q_cmd.occ    = tpf_pkg::OCC_W'(count_q + CNT_W'(1));
						end
					end
				end
			end
			tpf_pkg::OP_GET, tpf_pkg::OP_QUERY: begin
				if (valid_s1) begin
					if (count_q == '0) begin
						if (!q_full) begin
							done         = 1'b1;
							q_push       = 1'b1;
							q_cmd.status = tpf_pkg::ST_EMPTY;
						end
					end else if (!wait_s1) begin
						wait_d = 1'b1;
					end else if (!q_full) begin
						done         = 1'b1;
						wait_d       = 1'b0;
						q_push       = 1'b1;
						q_cmd.tag    = head_q.tag;
						q_cmd.length = head_len;
						q_cmd.status = tpf_pkg::ST_OK;
						if (item_s1.op == tpf_pkg::OP_GET) begin
							rslot_d      = rslot_nx;
							count_d      = count_q - CNT_W'(1);
							q_cmd.occ    = tpf_pkg::OCC_W'(count_q - CNT_W'(1));
							q_cmd.stream = (head_len != '0);
							pend_inc     = (head_len != '0);
						end else begin
							q_cmd.occ = tpf_pkg::OCC_W'(count_q);
						end
					end
				end
			end
			default: begin
				done = valid_s1;
			end
		endcase
		pend_d = pend_q + tpf_pkg::PEND_W'(pend_inc) - tpf_pkg::PEND_W'(stream_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wait_s1  <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
			wait_s1  <= 1'b0;
		end else if (done) begin
			valid_s1 <= 1'b0;
			wait_s1  <= 1'b0;
		end else begin
			wait_s1 <= wait_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			rslot_q <= '0;
			count_q <= '0;
			woff_q  <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= '0;
			ring_q  <= ring_of(tpf_pkg::CFG_RESET);
		end else if (cfg_write) begin
			wslot_q <= '0;
			rslot_q <= '0;
			count_q <= '0;
			woff_q  <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= '0;
			ring_q  <= ring_of(cfg_data);
		end else begin
			wslot_q <= wslot_d;
			rslot_q <= rslot_d;
			count_q <= count_d;
			woff_q  <= woff_d;
			ovf_q   <= ovf_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[wslot_q] <= '{length: woff_inc, tag: item_s1.tag};
		end
		head_q <= hdr_mem[rslot_q];
	end

endmodule

FILE: sv/tpf_queue.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO command queue
// Short queue of result commands between the front end and the back end.
// ----------------------------------------------------------------------------
module tpf_queue #(
	parameter int SLOT_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tpf_pkg::tpf_cmd_t    push_cmd,
	input  logic [SLOT_W-1:0]    push_slot,
	output logic                 full,
	output logic                 valid,
	input  logic                 pop,
	output tpf_pkg::tpf_cmd_t    head_cmd,
	output logic [SLOT_W-1:0]    head_slot
);

	localparam int CW = tpf_pkg::QP_W + 1;

	tpf_pkg::tpf_cmd_t         cmd_q  [tpf_pkg::Q_DEPTH];
	logic [SLOT_W-1:0]         slot_q [tpf_pkg::Q_DEPTH];
	logic [tpf_pkg::QP_W-1:0]  wp_q, rp_q;
	logic [CW-1:0]             cnt_q;

	assign full      = (cnt_q == CW'(tpf_pkg::Q_DEPTH));
	assign valid     = (cnt_q != '0);
	assign head_cmd  = cmd_q[rp_q];
	assign head_slot = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + tpf_pkg::QP_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + tpf_pkg::QP_W'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q]  <= push_cmd;
			slot_q[wp_q] <= push_slot;
		end
	end

endmodule

FILE: sv/tpf_back.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO back end
// Holds the payload store, expands commands into result beats and drives
// the output register.
// ----------------------------------------------------------------------------
module tpf_back #(
	parameter int SLOTS   = tpf_pkg::SLOTS_DEF,
	parameter int MAX_LEN = tpf_pkg::MAX_LEN_DEF,
	localparam int SLOT_W = $clog2(SLOTS),
	localparam int ADDR_W = $clog2(SLOTS * MAX_LEN)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mem_we,
	input  logic [ADDR_W-1:0]    mem_waddr,
	input  logic [7:0]           mem_wdata,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  tpf_pkg::tpf_cmd_t    q_cmd,
	input  logic [SLOT_W-1:0]    q_slot,
	output logic                 stream_done,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tpf_pkg::tpf_out_t    out_item
);

	logic [7:0] mem [SLOTS * MAX_LEN];

	logic                      cur_valid_q;
	tpf_pkg::tpf_cmd_t         cur_q;
	logic [SLOT_W-1:0]         cur_slot_q;
	logic [tpf_pkg::LEN_W-1:0] k_q;

	logic                      valid_s1;
	logic                      use_rd_s1;
	logic                      last_s1;
	tpf_pkg::tpf_cmd_t         cmd_s1;
	logic [7:0]                rdata_s1;

	logic                      out_valid_q;
	tpf_pkg::tpf_out_t         out_q;

	logic                      adv_s1, load_s1, issue, is_last;
	logic [ADDR_W-1:0]         raddr;

	assign adv_s1      = valid_s1 && (!out_valid_q || out_ready);
	assign load_s1     = !valid_s1 || adv_s1;
	assign issue       = cur_valid_q && load_s1;
	assign is_last     = !cur_q.stream || (k_q + tpf_pkg::LEN_W'(1) == cur_q.length);
	assign q_pop       = !cur_valid_q && q_valid;
	assign stream_done = issue && cur_q.stream && is_last;
	assign raddr       = ADDR_W'(cur_slot_q) * ADDR_W'(MAX_LEN) + ADDR_W'(k_q);
	assign out_valid   = out_valid_q;
	assign out_item    = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue && cur_q.stream) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
		end else if (issue && is_last) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= q_cmd;
			cur_slot_q <= q_slot;
			k_q        <= '0;
		end else if (issue) begin
			k_q <= k_q + tpf_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_rd_s1 <= cur_q.stream;
			last_s1   <= is_last;
			cmd_s1    <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.out_byte      <= use_rd_s1 ? rdata_s1 : 8'd0;
			out_q.out_last      <= last_s1;
			out_q.out_tag       <= cmd_s1.tag;
			out_q.packet_length <= cmd_s1.length;
			out_q.occupancy     <= cmd_s1.occ;
			out_q.status        <= cmd_s1.status;
		end
	end

endmodule

FILE: sv/tagged_packet_fifo_core.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO core
// Ring of packet slots with tags, streamed in and out one byte per beat.
// ----------------------------------------------------------------------------
// A put takes one payload byte per cycle when not stalled and gives one
// status beat on its last byte. A get or query first waits in the front
// end for the head slot header lookup; a get then streams its packet from
// the payload memory read port at one byte per cycle unless the output
// stalls, and the back end idles between commands. While a get is still
// streaming, put bytes wait in the front end, since the freed slot shares
// the payload memory. A config write sets the ring size and empties the FIFO.
module tagged_packet_fifo_core #(
	parameter int SLOTS   = tpf_pkg::SLOTS_DEF,
	parameter int MAX_LEN = tpf_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [tpf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tpf_pkg::tpf_in_t           in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tpf_pkg::tpf_out_t          out_item
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ADDR_W = $clog2(SLOTS * MAX_LEN);

	logic                q_full, q_push, q_valid, q_pop, stream_done, mem_we;
	tpf_pkg::tpf_cmd_t   push_cmd, head_cmd;
	logic [SLOT_W-1:0]   push_slot, head_slot;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;

	tpf_front #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd),
		.q_slot      (push_slot),
		.stream_done (stream_done),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	tpf_queue #(.SLOT_W(SLOT_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.push_slot (push_slot),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.head_cmd  (head_cmd),
		.head_slot (head_slot)
	);

	tpf_back #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_cmd       (head_cmd),
		.q_slot      (head_slot),
		.stream_done (stream_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

FILE: sv/tpf_checker.sv
// ----------------------------------------------------------------------------
// Tagged packet FIFO checker
// Port level checks on result beats, bound to the core.
// ----------------------------------------------------------------------------
module tpf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input tpf_pkg::tpf_out_t          out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat dropped or changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == tpf_pkg::ST_EMPTY |->
			out_item.out_last && out_item.occupancy == '0 &&
			out_item.packet_length == '0 && out_item.out_tag == '0)
		else $error("empty beat carries data");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == tpf_pkg::ST_FULL ||
			out_item.status == tpf_pkg::ST_LONG) |->
			out_item.out_last && out_item.packet_length == '0 &&
			out_item.out_byte == '0)
		else $error("rejected put beat carries data");

	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.out_last |->
			out_item.status == tpf_pkg::ST_OK && out_item.packet_length != '0)
		else $error("non-final beat outside a packet read");

endmodule

bind tagged_packet_fifo_core tpf_checker u_tpf_checker (.*);
